[sv/alignment_column_pair_scorer_core_defines.svh]
// Assertion macros shared by the alignment column pair scorer checkers.
`ifndef ALIGNMENT_COLUMN_PAIR_SCORER_CORE_DEFINES_SVH
`define ALIGNMENT_COLUMN_PAIR_SCORER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACPS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("acps checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACPS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("acps checker: next-cycle property failed");

// Next-cycle implication that also watches reset itself.
`define ACPS_ASSERT_RST(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("acps checker: reset property failed");

`endif

[sv/acps_pkg.sv]
// Types, constants and scoring functions of the alignment column pair scorer.
`default_nettype none

package acps_pkg;

  localparam int MAX_ROWS      = 8;
  localparam int ALPHABET_SIZE = 128;
  localparam int NUM_PAIRS     = MAX_ROWS * (MAX_ROWS - 1) / 2;
  localparam int GROUP_SIZE    = 7;
  localparam int NUM_GROUPS    = NUM_PAIRS / GROUP_SIZE;

  localparam int CHAR_W     = 8;
  localparam int SCORE_W    = 11;  // pair score incl. gap open: -757 .. 100
  localparam int PART_W     = 14;  // seven pair scores
  localparam int COL_W      = 16;  // whole column
  localparam int SUM_W      = 40;
  localparam int ROW_CNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef logic [CHAR_W-1:0]           char_t;
  typedef logic signed [SCORE_W-1:0]   score_t;
  typedef logic signed [PART_W-1:0]    part_t;
  typedef logic signed [COL_W-1:0]     col_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [SUM_W:0]       sumx_t;
  typedef logic [ROW_CNT_W-1:0]        row_cnt_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t CFG_SCORE_SET = 1'd0;
  localparam cfg_idx_t CFG_ROW_COUNT = 1'd1;

  localparam row_cnt_t ROW_COUNT_RST = 4'd2;

  localparam char_t CHAR_DASH = 8'h2D;
  localparam char_t CHAR_A_UC = 8'h41;
  localparam char_t CHAR_A_LC = 8'h61;
  localparam char_t CHAR_C_UC = 8'h43;
  localparam char_t CHAR_C_LC = 8'h63;
  localparam char_t CHAR_G_UC = 8'h47;
  localparam char_t CHAR_G_LC = 8'h67;
  localparam char_t CHAR_T_UC = 8'h54;
  localparam char_t CHAR_T_LC = 8'h74;

  localparam score_t UNSPEC_SCORE = -11'sd100;

  localparam score_t OPEN_COST   [2] = '{11'sd400, 11'sd600};
  localparam score_t EXTEND_COST [2] = '{11'sd30,  11'sd50};

  localparam score_t SUBST_TBL [2][4][4] = '{
    '{ '{ 11'sd91,  -11'sd114, -11'sd31,  -11'sd123},
       '{-11'sd114,  11'sd100, -11'sd125, -11'sd31 },
       '{-11'sd31,  -11'sd125,  11'sd100, -11'sd114},
       '{-11'sd123, -11'sd31,  -11'sd114,  11'sd91 } },
    '{ '{ 11'sd86,  -11'sd135, -11'sd68,  -11'sd157},
       '{-11'sd135,  11'sd100, -11'sd148, -11'sd68 },
       '{-11'sd68,  -11'sd148,  11'sd100, -11'sd135},
       '{-11'sd157, -11'sd68,  -11'sd135,  11'sd86 } }
  };

  // Indexed by {prev_r, prev_s, cur_r, cur_s} dash bits: XXXD, XXDX, XDDX, DXXD, DDXD, DDDX
  localparam logic [15:0] GAP_OPEN_MASK = 16'h6246;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic in_range;
    logic last;
  } ctl_t;

  // bit 2: known nucleotide, bits 1:0: A, C, G, T
  function automatic logic [2:0] base_code(input char_t ch);
    logic [2:0] code;
    case (ch)
      CHAR_A_UC, CHAR_A_LC: code = 3'b100;
      CHAR_C_UC, CHAR_C_LC: code = 3'b101;
      CHAR_G_UC, CHAR_G_LC: code = 3'b110;
      CHAR_T_UC, CHAR_T_LC: code = 3'b111;
      default:              code = 3'b000;
    endcase
    return code;
  endfunction

  function automatic score_t pair_score(input char_t p, input char_t q, input logic set);
    logic [2:0] bp;
    logic [2:0] bq;
    score_t     s;
    bp = base_code(p);
    bq = base_code(q);
    if ((int'(p) >= ALPHABET_SIZE) || (int'(q) >= ALPHABET_SIZE)) begin
      s = UNSPEC_SCORE;
    end else if ((p == CHAR_DASH) && (q == CHAR_DASH)) begin
      s = '0;
    end else if ((p == CHAR_DASH) || (q == CHAR_DASH)) begin
      s = -EXTEND_COST[set];
    end else if (!bp[2] || !bq[2]) begin
      s = UNSPEC_SCORE;
    end else begin
      s = SUBST_TBL[set][bp[1:0]][bq[1:0]];
    end
    return s;
  endfunction

  function automatic logic gap_opens(input logic a, input logic b, input logic c,
                                     input logic d);
    return GAP_OPEN_MASK[{a, b, c, d}];
  endfunction

endpackage

`default_nettype wire

[sv/alignment_column_pair_scorer_core.sv]
// Top level of the alignment column pair scorer: lanes, merge tree, accumulator, control.
`default_nettype none

// Sum-of-pairs scorer for a DNA multiple alignment, one column per transaction.
// The block accepts one column in every clock cycle for as long as results are
// taken. A final column's result reaches the output through the pair lanes,
// which register at the accepting edge, then the group partials, the column
// sum and the saturating accumulator with its result register.
// Twenty-eight pair lanes score every row pair of the column at once, and a
// two-level registered adder tree merges them. Only a column flagged
// last_in_range produces a result transaction; while such a result waits on
// out_ready, non-final columns still drain, and in_ready drops only once the
// pipeline backs up behind a second pending final column. The dash mask of the
// previous column is taken at acceptance, so has_previous refers to the column
// accepted just before. score_set selects the table and the gap-open/extend
// costs; row_count above eight acts as eight, and zero or one scores nothing.
// Write the configuration only while no column is in flight.

module alignment_column_pair_scorer_core (
  input  wire                                  clk,
  input  wire                                  rst_n,

  input  wire                                  cfg_we,
  input  wire [acps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [acps_pkg::CFG_DATA_W-1:0]       cfg_wdata,

  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire [7:0]                            in_row_char_0,
  input  wire [7:0]                            in_row_char_1,
  input  wire [7:0]                            in_row_char_2,
  input  wire [7:0]                            in_row_char_3,
  input  wire [7:0]                            in_row_char_4,
  input  wire [7:0]                            in_row_char_5,
  input  wire [7:0]                            in_row_char_6,
  input  wire [7:0]                            in_row_char_7,
  input  wire                                  in_has_previous,
  input  wire                                  in_in_range,
  input  wire                                  in_last_in_range,

  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [39:0]                   out_range_score,
  output logic                                 out_saturated
);

  // Configuration registers
  logic                 score_set_r;
  acps_pkg::row_cnt_t   row_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_set_r <= 1'b0;
      row_count_r <= acps_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acps_pkg::CFG_SCORE_SET: score_set_r <= cfg_wdata[0];
        acps_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata[acps_pkg::ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Column characters, current dash mask and active rows
  acps_pkg::char_t              row_char [acps_pkg::MAX_ROWS];
  logic [acps_pkg::MAX_ROWS-1:0] cur_dash;
  logic [acps_pkg::MAX_ROWS-1:0] row_en;
  logic [acps_pkg::MAX_ROWS-1:0] prev_dash_r;

  assign row_char[0] = in_row_char_0;
  assign row_char[1] = in_row_char_1;
  assign row_char[2] = in_row_char_2;
  assign row_char[3] = in_row_char_3;
  assign row_char[4] = in_row_char_4;
  assign row_char[5] = in_row_char_5;
  assign row_char[6] = in_row_char_6;
  assign row_char[7] = in_row_char_7;

  always_comb begin
    for (int i = 0; i < acps_pkg::MAX_ROWS; i++) begin
      cur_dash[i] = row_char[i] == acps_pkg::CHAR_DASH;
      // counts above the row total enable every row
      row_en[i]   = row_count_r > acps_pkg::row_cnt_t'(i);
    end
  end

  // Pipeline control: stage 1 lanes, stage 2 partials, stage 3 column sum.
  // Stage 3 retires into the accumulator; a final column also needs the
  // result register free.
  logic           in_fire;
  logic           v1_r, v2_r, v3_r;
  acps_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r;
  acps_pkg::ctl_t in_ctl;
  logic           adv1, adv2, adv3;
  logic           free1, free2, free3;

  assign in_ctl.in_range = in_in_range;
  assign in_ctl.last     = in_last_in_range;

  always_comb begin
    adv3     = v3_r & (~ctl3_r.last | ~out_valid | out_ready);
    free3    = ~v3_r | adv3;
    adv2     = v2_r & free3;
    free2    = ~v2_r | adv2;
    adv1     = v1_r & free2;
    free1    = ~v1_r | adv1;
    in_ready = free1;
    in_fire  = in_valid & free1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      prev_dash_r <= '0;
    end else begin
      v1_r <= in_fire | (v1_r & ~adv1);
      v2_r <= adv1    | (v2_r & ~adv2);
      v3_r <= adv2    | (v3_r & ~adv3);
      // hold the dash mask of the most recently accepted column
      if (in_fire) begin
        prev_dash_r <= cur_dash;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl1_r <= in_ctl;
    end
    if (adv1) begin
      ctl2_r <= ctl1_r;
    end
    if (adv2) begin
      ctl3_r <= ctl2_r;
    end
  end

  // Pair lanes: one per row pair (r < s), active when row s is present
  acps_pkg::score_t lane_score [acps_pkg::NUM_PAIRS];

  for (genvar r = 0; r < acps_pkg::MAX_ROWS - 1; r++) begin : g_row
    for (genvar s = r + 1; s < acps_pkg::MAX_ROWS; s++) begin : g_pair
      localparam int LaneIdx = (acps_pkg::MAX_ROWS - 1) * r - (r * (r - 1)) / 2
                             + (s - r - 1);
      acps_pair_lane u_lane (
        .clk         (clk),
        .en          (in_fire),
        .char_p      (row_char[r]),
        .char_q      (row_char[s]),
        .prev_dash_p (prev_dash_r[r]),
        .prev_dash_q (prev_dash_r[s]),
        .has_prev    (in_has_previous),
        .score_set   (score_set_r),
        .active      (row_en[s]),
        .score_r     (lane_score[LaneIdx])
      );
    end
  end

  // Merge lanes into a column score
  acps_pkg::col_t col_sum;

  acps_col_merge u_merge (
    .clk        (clk),
    .part_en    (adv1),
    .col_en     (adv2),
    .lane_score (lane_score),
    .col_sum_r  (col_sum)
  );

  // Running range sum and result register
  acps_accum u_accum (
    .clk             (clk),
    .rst_n           (rst_n),
    .retire          (adv3),
    .ctl             (ctl3_r),
    .col_sum         (col_sum),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_range_score (out_range_score),
    .out_saturated   (out_saturated)
  );

endmodule

`default_nettype wire

[sv/acps_pair_lane.sv]
// One row-pair scoring lane: substitution/gap score plus gap-open penalty, registered.
`default_nettype none

module acps_pair_lane (
  input  wire                    clk,
  input  wire                    en,
  input  wire acps_pkg::char_t   char_p,
  input  wire acps_pkg::char_t   char_q,
  input  wire                    prev_dash_p,
  input  wire                    prev_dash_q,
  input  wire                    has_prev,
  input  wire                    score_set,
  input  wire                    active,
  output acps_pkg::score_t       score_r
);

  acps_pkg::score_t pair;
  acps_pkg::score_t score_nxt;
  logic             open;

  always_comb begin
    pair = acps_pkg::pair_score(char_p, char_q, score_set);
    open = has_prev && acps_pkg::gap_opens(prev_dash_p, prev_dash_q,
                                           char_p == acps_pkg::CHAR_DASH,
                                           char_q == acps_pkg::CHAR_DASH);
    if (!active) begin
      score_nxt = '0;
    end else if (open) begin
      score_nxt = pair - acps_pkg::OPEN_COST[score_set];
    end else begin
      score_nxt = pair;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r <= score_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/acps_col_merge.sv]
// Two-level registered adder tree: lane scores to group partials to a column sum.
`default_nettype none

module acps_col_merge (
  input  wire                 clk,
  input  wire                 part_en,
  input  wire                 col_en,
  input  acps_pkg::score_t    lane_score [acps_pkg::NUM_PAIRS],
  output acps_pkg::col_t      col_sum_r
);

  acps_pkg::part_t part_r   [acps_pkg::NUM_GROUPS];
  acps_pkg::part_t part_nxt [acps_pkg::NUM_GROUPS];
  acps_pkg::col_t  col_nxt;

  // Group partials
  always_comb begin
    for (int g = 0; g < acps_pkg::NUM_GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < acps_pkg::GROUP_SIZE; k++) begin
        part_nxt[g] = part_nxt[g]
                    + acps_pkg::part_t'(lane_score[g*acps_pkg::GROUP_SIZE + k]);
      end
    end
  end

  always_comb begin
    col_nxt = '0;
    for (int g = 0; g < acps_pkg::NUM_GROUPS; g++) begin
      col_nxt = col_nxt + acps_pkg::col_t'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (part_en) begin
      part_r <= part_nxt;
    end
    if (col_en) begin
      col_sum_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/acps_accum.sv]
// Saturating 40-bit range accumulator with sticky flag and result register.
`default_nettype none

module acps_accum (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 retire,
  input  wire acps_pkg::ctl_t ctl,
  input  wire acps_pkg::col_t col_sum,
  input  wire                 out_ready,
  output logic                out_valid,
  output acps_pkg::sum_t      out_range_score,
  output logic                out_saturated
);

  acps_pkg::sum_t  running_sum_r;
  acps_pkg::sum_t  running_sum_nxt;
  logic            sum_sat_r;
  logic            sum_sat_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  acps_pkg::sum_t  out_score_r;
  logic            out_sat_r;
  acps_pkg::sumx_t total;
  logic            ovf;
  acps_pkg::sum_t  add_sum;
  acps_pkg::sum_t  upd_sum;
  logic            upd_sat;

  always_comb begin
    total   = acps_pkg::sumx_t'(running_sum_r) + acps_pkg::sumx_t'(col_sum);
    ovf     = total[acps_pkg::SUM_W] != total[acps_pkg::SUM_W-1];
    if (ovf) begin
      add_sum = total[acps_pkg::SUM_W] ? acps_pkg::SUM_MIN : acps_pkg::SUM_MAX;
    end else begin
      add_sum = total[acps_pkg::SUM_W-1:0];
    end
    upd_sum = ctl.in_range ? add_sum : running_sum_r;
    upd_sat = sum_sat_r | (ctl.in_range & ovf);

    running_sum_nxt = running_sum_r;
    sum_sat_nxt     = sum_sat_r;
    if (retire) begin
      if (ctl.last) begin
        running_sum_nxt = '0;
        sum_sat_nxt     = 1'b0;
      end else begin
        running_sum_nxt = upd_sum;
        sum_sat_nxt     = upd_sat;
      end
    end
    out_valid_nxt = (retire & ctl.last) | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      sum_sat_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      running_sum_r <= running_sum_nxt;
      sum_sat_r     <= sum_sat_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && ctl.last) begin
      out_score_r <= upd_sum;
      out_sat_r   <= upd_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_score = out_score_r;
  assign out_saturated   = out_sat_r;

endmodule

`default_nettype wire

[sv/acps_checker.sv]
// Port-level checker for the alignment column pair scorer, bound to the top level.
`default_nettype none

`include "alignment_column_pair_scorer_core_defines.svh"

module acps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [39:0] out_range_score,
  input wire        out_saturated
);

  // Reset drops any pending result
  `ACPS_ASSERT_RST(a_rst_clears_out, clk, !rst_n, !out_valid)

  // Input back-pressure only comes from a result that is not being taken
  `ACPS_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

  `ACPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  `ACPS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_range_score) && $stable(out_saturated))

endmodule

bind alignment_column_pair_scorer_core acps_checker u_acps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_range_score (out_range_score),
  .out_saturated   (out_saturated)
);

`default_nettype wire

[test/range_score_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the alignment column pair scorer: predicts range scores and checks each result.
module range_score_checker
  import acps_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                    in_valid,
  input  wire                    in_ready,
  input  wire [7:0]              in_row_char_0,
  input  wire [7:0]              in_row_char_1,
  input  wire [7:0]              in_row_char_2,
  input  wire [7:0]              in_row_char_3,
  input  wire [7:0]              in_row_char_4,
  input  wire [7:0]              in_row_char_5,
  input  wire [7:0]              in_row_char_6,
  input  wire [7:0]              in_row_char_7,
  input  wire                    in_has_previous,
  input  wire                    in_in_range,
  input  wire                    in_last_in_range,
  input  wire                    out_valid,
  input  wire                    out_ready,
  input  wire signed [39:0]      out_range_score,
  input  wire                    out_saturated,
  output int                     mismatches,
  output int                     pending,
  output int                     scores_checked
);

  typedef struct packed {
    logic signed [SUM_W-1:0] score;
    logic                    sat;
  } range_result_t;

  localparam longint SUM_CEIL  = 64'sd549755813887;
  localparam longint SUM_FLOOR = -64'sd549755813888;

  localparam int UNKNOWN_PAIR = -100;
  localparam int EXTEND_HR    = 30;
  localparam int EXTEND_MR    = 50;
  localparam int OPEN_HR      = 400;
  localparam int OPEN_MR      = 600;

  logic            score_set_q;
  logic [3:0]      row_count_q;
  logic [7:0]      prev_dashes;
  longint          range_sum;
  logic            range_sat;
  range_result_t   expected_ranges[$];
  int              error_count;
  int              checked_count;

  // A=0 C=1 G=2 T=3 in either case, -1 for anything else
  function automatic int nucleotide_index(input logic [7:0] ch);
    case (ch)
      "A", "a": return 0;
      "C", "c": return 1;
      "G", "g": return 2;
      "T", "t": return 3;
      default:  return -1;
    endcase
  endfunction

  // Both tables are symmetric, so key on the ordered pair
  function automatic int substitution(input logic set, input int bp, input int bq);
    int         lo;
    int         hi;
    logic [4:0] key;
    lo  = (bp < bq) ? bp : bq;
    hi  = (bp < bq) ? bq : bp;
    key = {set, lo[1:0], hi[1:0]};
    case (key)
      5'b0_00_00: return 91;
      5'b0_00_01: return -114;
      5'b0_00_10: return -31;
      5'b0_00_11: return -123;
      5'b0_01_01: return 100;
      5'b0_01_10: return -125;
      5'b0_01_11: return -31;
      5'b0_10_10: return 100;
      5'b0_10_11: return -114;
      5'b0_11_11: return 91;
      5'b1_00_00: return 86;
      5'b1_00_01: return -135;
      5'b1_00_10: return -68;
      5'b1_00_11: return -157;
      5'b1_01_01: return 100;
      5'b1_01_10: return -148;
      5'b1_01_11: return -68;
      5'b1_10_10: return 100;
      5'b1_10_11: return -135;
      5'b1_11_11: return 86;
      default:    return 0;
    endcase
  endfunction

  function automatic int pair_value(input logic [7:0] p, input logic [7:0] q, input logic set);
    int bp;
    int bq;
    bp = nucleotide_index(p);
    bq = nucleotide_index(q);
    // characters past the alphabet lose even against a dash
    if (int'(p) >= ALPHABET_SIZE || int'(q) >= ALPHABET_SIZE) return UNKNOWN_PAIR;
    if (p == CHAR_DASH && q == CHAR_DASH) return 0;
    if (p == CHAR_DASH || q == CHAR_DASH) return set ? -EXTEND_MR : -EXTEND_HR;
    if (bp < 0 || bq < 0) return UNKNOWN_PAIR;
    return substitution(set, bp, bq);
  endfunction

  // {prev r, prev s, cur r, cur s} dash bits
  function automatic logic gap_opened(input logic [3:0] pattern);
    case (pattern)
      4'd1, 4'd2, 4'd6, 4'd9, 4'd13, 4'd14: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0]    ch [MAX_ROWS];
    logic [7:0]    dashes;
    int            rows;
    int            col;
    longint        total;
    range_result_t exp_r;
    if (!rst_n) begin
      score_set_q = 1'b0;
      row_count_q = 4'd2;
      prev_dashes = '0;
      range_sum   = 0;
      range_sat   = 1'b0;
      expected_ranges.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ranges.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: expected none, actual score %0d sat %0b",
                   $time, out_range_score, out_saturated);
        end else begin
          exp_r = expected_ranges.pop_front();
          checked_count++;
          if (out_range_score !== exp_r.score) begin
            error_count++;
            $display("%0t: range_score mismatch: expected %0d, actual %0d",
                     $time, exp_r.score, out_range_score);
          end
          if (out_saturated !== exp_r.sat) begin
            error_count++;
            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                     $time, exp_r.sat, out_saturated);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_SCORE_SET: score_set_q = cfg_wdata[0];
          CFG_ROW_COUNT: row_count_q = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        ch[0] = in_row_char_0;
        ch[1] = in_row_char_1;
        ch[2] = in_row_char_2;
        ch[3] = in_row_char_3;
        ch[4] = in_row_char_4;
        ch[5] = in_row_char_5;
        ch[6] = in_row_char_6;
        ch[7] = in_row_char_7;
        for (int r = 0; r < MAX_ROWS; r++) dashes[r] = (ch[r] == CHAR_DASH);
        rows = (row_count_q > MAX_ROWS) ? MAX_ROWS : int'(row_count_q);
        col  = 0;
        for (int r = 0; r < rows; r++) begin
          for (int s = r + 1; s < rows; s++) begin
            col += pair_value(ch[r], ch[s], score_set_q);
            if (in_has_previous &&
                gap_opened({prev_dashes[r], prev_dashes[s], dashes[r], dashes[s]}))
              col -= score_set_q ? OPEN_MR : OPEN_HR;
          end
        end
        // the dash mask follows every column, in range or not
        prev_dashes = dashes;
        if (in_in_range) begin
          total = range_sum + col;
          if (total > SUM_CEIL) begin
            total     = SUM_CEIL;
            range_sat = 1'b1;
          end
          if (total < SUM_FLOOR) begin
            total     = SUM_FLOOR;
            range_sat = 1'b1;
          end
          range_sum = total;
        end
        if (in_last_in_range) begin
          exp_r.score = range_sum[SUM_W-1:0];
          exp_r.sat   = range_sat;
          expected_ranges.push_back(exp_r);
          range_sum = 0;
          range_sat = 1'b0;
        end
      end
    end
    mismatches     <= error_count;
    pending        <= expected_ranges.size();
    scores_checked <= checked_count;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the alignment column pair scorer testbench: clock, reset, column stimulus and verdict.
module testbench;
  import acps_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;

  // Register settings per random phase; row counts include 0, 1 and values past eight
  localparam logic [PHASES-1:0]   PHASE_SET  = 12'b0101_1010_0110;
  localparam logic [4*PHASES-1:0] PHASE_ROWS = {4'd8, 4'd3, 4'd2, 4'd0, 4'd1, 4'd15,
                                                4'd9, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic [7:0]            in_row_char_0 = '0;
  logic [7:0]            in_row_char_1 = '0;
  logic [7:0]            in_row_char_2 = '0;
  logic [7:0]            in_row_char_3 = '0;
  logic [7:0]            in_row_char_4 = '0;
  logic [7:0]            in_row_char_5 = '0;
  logic [7:0]            in_row_char_6 = '0;
  logic [7:0]            in_row_char_7 = '0;
  logic                  in_has_previous = 1'b0;
  logic                  in_in_range = 1'b0;
  logic                  in_last_in_range = 1'b0;
  logic                  out_ready = 1'b0;
  wire                   in_ready;
  wire                   out_valid;
  wire signed [39:0]     out_range_score;
  wire                   out_saturated;

  int   mismatches;
  int   pending;
  int   scores_checked;
  int   columns_sent = 0;
  int   hold_token = 0;   // bump to ask the receiver for one long stall
  logic quiet = 1'b0;     // no idling on either side once set

  alignment_column_pair_scorer_core DUT (.*);

  range_score_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #1000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Offer one column and hold it until accepted. Optionally drop valid for an idle
  // burst first; otherwise keep valid high so back-to-back transactions flow.
  task automatic drive_column(input logic [63:0] chars, input logic prev_col,
                              input logic in_rng, input logic last_col, input logic no_idle);
    int gap;
    if (!quiet && !no_idle && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_row_char_0    <= chars[63:56];
    in_row_char_1    <= chars[55:48];
    in_row_char_2    <= chars[47:40];
    in_row_char_3    <= chars[39:32];
    in_row_char_4    <= chars[31:24];
    in_row_char_5    <= chars[23:16];
    in_row_char_6    <= chars[15:8];
    in_row_char_7    <= chars[7:0];
    in_has_previous  <= prev_col;
    in_in_range      <= in_rng;
    in_last_in_range <= last_col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    columns_sent++;
  endtask

  // Drop valid, wait for every expected score, then let columns without a result
  // clear the pipeline so the registers can be rewritten safely.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; spare data bits of score_set carry noise.
  task automatic write_config(input logic set, input logic [3:0] rows);
    logic [CFG_DATA_W-2:0] spare;
    spare      = (CFG_DATA_W-1)'($urandom_range(0, 2**(CFG_DATA_W-1) - 1));
    cfg_we     <= 1'b1;
    cfg_index  <= CFG_SCORE_SET;
    cfg_wdata  <= {spare, set};
    @(posedge clk);
    cfg_index  <= CFG_ROW_COUNT;
    cfg_wdata  <= rows;
    @(posedge clk);
    cfg_we     <= 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin : receiver
    int holds_served;
    int stall;
    holds_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_token != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 19);
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] col;
    logic [63:0] letters;
    logic [7:0]  ch;
    logic [7:0]  gap_rows;
    logic        prev_col;
    logic        in_rng;
    logic        last_col;
    logic        pressure;
    int          pick;
    letters  = "ACGTacgt";
    gap_rows = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed columns on all eight rows with the first table: both letter cases,
    // dash runs that open and extend gaps, unknown letters, bytes at and past the
    // alphabet edge (also against a dash), a first column, an out-of-range column
    // that still moves the dash mask, and a last column that adds nothing.
    write_config(1'b0, 4'd8);
    drive_column("ACGTacgt", 1'b0, 1'b1, 1'b0, 1'b0);
    drive_column("--------", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("A-C-G-T-", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("AAAA----", 1'b1, 1'b1, 1'b1, 1'b0);
    drive_column("NNnn-xyz", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column({8'h00, 8'hFF, 8'h80, "-", 8'h7F, "A", 8'hFE, "t"}, 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column(64'h0, 1'b1, 1'b1, 1'b1, 1'b0);
    drive_column({8{8'hFF}}, 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("acgtACGT", 1'b0, 1'b0, 1'b1, 1'b0);
    drive_column("TTTTTTTT", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("-A-A-A-A", 1'b0, 1'b1, 1'b0, 1'b0);
    drive_column("A-A-A-A-", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("AA--AA--", 1'b1, 1'b1, 1'b0, 1'b0);
    drive_column("--AA--AA", 1'b1, 1'b0, 1'b0, 1'b0);
    drive_column("-A-A-A-A", 1'b1, 1'b1, 1'b1, 1'b0);
    drive_column("gGcCaAtT", 1'b1, 1'b1, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      // Final phase runs with both sides at full rate
      if (p == PHASES - 1) quiet <= 1'b1;
      write_config(PHASE_SET[p], PHASE_ROWS[4*(PHASES-1-p) +: 4]);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        // In the first phase stall the receiver for a long stretch while columns
        // full of range ends keep coming, so the block backs up and drops in_ready.
        pressure = (p == 0 && j >= 10 && j < 50);
        if (p == 0 && j == 10) hold_token <= hold_token + 1;

        // Rows wander in and out of dash runs so gaps open, extend and close
        for (int r = 0; r < MAX_ROWS; r++) begin
          if ($urandom_range(0, 99) < 12) gap_rows[r] = ~gap_rows[r];
          pick = $urandom_range(0, 99);
          if (gap_rows[r] && pick < 95)
            ch = CHAR_DASH;
          else if (pick < 75)
            ch = letters[8*$urandom_range(0, 7) +: 8];
          else if (pick < 88)
            ch = 8'($urandom_range(0, 127));
          else
            ch = 8'($urandom_range(0, 255));
          col[8*(7-r) +: 8] = ch;
        end
        prev_col = ($urandom_range(0, 99) >= 4);
        in_rng   = ($urandom_range(0, 99) < 92);
        last_col = ($urandom_range(0, 99) < (pressure ? 60 : 12));
        drive_column(col, prev_col, in_rng, last_col, pressure);
      end
      settle();
    end

    $display("covered %0d columns over %0d register settings, %0d range scores checked",
             columns_sent, PHASES + 1, scores_checked);
    $display("with idle bursts on both sides, one long result stall and a full-rate tail");
    if (mismatches == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/acps_pkg.sv
sv/acps_pair_lane.sv
sv/acps_col_merge.sv
sv/acps_accum.sv
sv/alignment_column_pair_scorer_core.sv
sv/acps_checker.sv
test/range_score_checker.sv
test/testbench.sv
